// File: hdl/mbsr_pkg.sv
`default_nettype none

package mbsr_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned IDX_W  = 12;
    localparam int unsigned LEN_W  = 13;

    localparam logic [BYTE_W-1:0] C_SOX = 8'hF0;
    localparam logic [BYTE_W-1:0] C_EOX = 8'hF7;
    localparam logic [3:0]        C_SYS_NIBBLE = 4'hF;

    // index of the last byte of a channel message (status, data1, data2)
    localparam logic [1:0] C_MSG_LAST = 2'd2;
    localparam logic [1:0] C_MSG_DONE = 2'd3;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        logic              msg_valid;
        t_byte             msg_status;
        t_byte             msg_data1;
        t_byte             msg_data2;
        logic              sysex_store_valid;
        t_byte             sysex_byte;
        logic [IDX_W-1:0]  sysex_index;
        logic              sysex_done;
        logic [LEN_W-1:0]  sysex_length;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/mbsr_if.sv
`default_nettype none

interface mbsr_byte_if;
    import mbsr_pkg::*;

    logic  valid;
    logic  ready;
    t_byte in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface mbsr_result_if;
    import mbsr_pkg::*;

    logic             valid;
    logic             ready;
    logic             msg_valid;
    t_byte            msg_status;
    t_byte            msg_data1;
    t_byte            msg_data2;
    logic             sysex_store_valid;
    t_byte            sysex_byte;
    logic [IDX_W-1:0] sysex_index;
    logic             sysex_done;
    logic [LEN_W-1:0] sysex_length;

    modport source (
        output valid, input ready,
        output msg_valid, output msg_status, output msg_data1, output msg_data2,
        output sysex_store_valid, output sysex_byte, output sysex_index,
        output sysex_done, output sysex_length
    );
    modport sink (
        input valid, output ready,
        input msg_valid, input msg_status, input msg_data1, input msg_data2,
        input sysex_store_valid, input sysex_byte, input sysex_index,
        input sysex_done, input sysex_length
    );
endinterface

`default_nettype wire

// File: hdl/mbsr_decode.sv
`default_nettype none

module mbsr_decode #(
    parameter int unsigned SYSEX_BUF_LEN = 4096
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_advance,
    input  wire mbsr_pkg::t_byte  i_byte,
    output mbsr_pkg::t_result     o_result
);
    import mbsr_pkg::*;

    localparam int unsigned CW = $clog2(SYSEX_BUF_LEN + 1);
    localparam logic [CW-1:0] C_CNT_LAST = CW'(SYSEX_BUF_LEN - 1);

    logic          r_sx_act, n_sx_act;
    logic [CW-1:0] r_sx_cnt, n_sx_cnt;
    logic          r_msg_act, n_msg_act;
    logic [1:0]    r_msg_cnt, n_msg_cnt;
    t_byte         r_held0, n_held0;
    t_byte         r_held1, n_held1;

    logic          is_sox, is_eox, is_chan, is_drop;
    logic          sx_act_mid, msg_act_mid;
    logic [CW-1:0] sx_cnt_mid;
    logic [1:0]    msg_cnt_mid;
    logic [CW+LEN_W-1:0] idx_ext, len_ext;

    always_comb begin
        is_sox  = (i_byte == C_SOX);
        is_eox  = (i_byte == C_EOX);
        is_chan = i_byte[7] && (i_byte[7:4] != C_SYS_NIBBLE);
        is_drop = (i_byte[7:4] == C_SYS_NIBBLE) && !is_sox && !is_eox;

        sx_act_mid  = is_sox ? 1'b1 : (is_eox ? 1'b0 : r_sx_act);
        sx_cnt_mid  = is_sox ? '0 : r_sx_cnt;
        msg_act_mid = is_chan ? 1'b1 : r_msg_act;
        msg_cnt_mid = is_chan ? 2'd0 : r_msg_cnt;

        idx_ext = {{LEN_W{1'b0}}, sx_cnt_mid};
        len_ext = {{LEN_W{1'b0}}, r_sx_cnt};

        n_sx_act  = r_sx_act;
        n_sx_cnt  = r_sx_cnt;
        n_msg_act = r_msg_act;
        n_msg_cnt = r_msg_cnt;
        n_held0   = r_held0;
        n_held1   = r_held1;
        o_result  = '0;

        if (!is_drop) begin
            n_sx_act  = sx_act_mid;
            n_sx_cnt  = sx_cnt_mid;
            n_msg_act = msg_act_mid;
            n_msg_cnt = msg_cnt_mid;

            if (is_eox) begin
                o_result.sysex_done   = 1'b1;
                o_result.sysex_length = len_ext[LEN_W-1:0];
            end

            if (sx_act_mid) begin
                o_result.sysex_store_valid = 1'b1;
                o_result.sysex_byte        = i_byte;
                o_result.sysex_index       = idx_ext[IDX_W-1:0];
                n_sx_cnt = sx_cnt_mid + 1'b1;
                // stop storing once the buffer is full
                n_sx_act = (sx_cnt_mid != C_CNT_LAST);
            end

            if (msg_act_mid) begin
                if (msg_cnt_mid == C_MSG_LAST) begin
                    n_msg_cnt = C_MSG_DONE;
                    n_msg_act = 1'b0;
                    o_result.msg_valid  = 1'b1;
                    o_result.msg_status = r_held0;
                    o_result.msg_data1  = r_held1;
                    o_result.msg_data2  = i_byte;
                end else begin
                    if (msg_cnt_mid == 2'd0) begin
                        n_held0 = i_byte;
                    end else begin
                        n_held1 = i_byte;
                    end
                    n_msg_cnt = msg_cnt_mid + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx_act  <= 1'b0;
            r_sx_cnt  <= '0;
            r_msg_act <= 1'b0;
            r_msg_cnt <= 2'd0;
        end else if (i_advance) begin
            r_sx_act  <= n_sx_act;
            r_sx_cnt  <= n_sx_cnt;
            r_msg_act <= n_msg_act;
            r_msg_cnt <= n_msg_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_held0 <= n_held0;
            r_held1 <= n_held1;
        end
    end

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sx_act |-> (r_sx_cnt <= C_CNT_LAST))
        else $error("sysex count past buffer while capture active");

    a_msg_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.msg_valid |-> (r_msg_act && r_msg_cnt == C_MSG_LAST))
        else $error("message completed without two held bytes");

    a_store_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_result.sysex_store_valid && o_result.sysex_done))
        else $error("end of exclusive byte was stored");

    a_sox_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && i_byte == C_SOX) |=> (r_sx_act && r_sx_cnt == CW'(1)))
        else $error("start of exclusive did not restart capture");

endmodule

`default_nettype wire

// File: hdl/midi_byte_stream_receiver_core.sv
// MIDI byte stream receiver.
//
// i_byte carries one received MIDI byte per request (valid/ready). o_res
// carries one result per accepted byte: a completed three-byte channel
// message (msg_*), a sysex byte stored at its buffer index (sysex_store_valid,
// sysex_byte, sysex_index) and the end of exclusive flag with the stored count
// (sysex_done, sysex_length). Fields not flagged valid read as zero.
//
// An accepted byte waits in the input register, and its result is loaded into
// the result register when that register is empty or being taken. Throughput
// is one byte per cycle while o_res.ready stays high; the parse state updates
// in a single pass as a byte moves into the result register.
//
// Reset clears both captures and empties both registers. When the receiver
// holds o_res.ready low, the result register holds its request and the input
// register takes one more byte, after which i_byte.ready drops until the
// result is taken.
`default_nettype none

module midi_byte_stream_receiver_core #(
    parameter int unsigned SYSEX_BUF_LEN = 4096
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    mbsr_byte_if.sink          i_byte,
    mbsr_result_if.source      o_res
);
    import mbsr_pkg::*;

    logic    r_in_vld;
    t_byte   r_in_byte;
    logic    r_out_vld;
    t_result r_out;
    t_result dec_result;
    logic    advance;

    assign advance      = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_byte.ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_vld <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.in_byte;
        end
    end

    mbsr_decode #(
        .SYSEX_BUF_LEN(SYSEX_BUF_LEN)
    ) u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(advance),
        .i_byte   (r_in_byte),
        .o_result (dec_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= dec_result;
        end
    end

    assign o_res.valid             = r_out_vld;
    assign o_res.msg_valid         = r_out.msg_valid;
    assign o_res.msg_status        = r_out.msg_status;
    assign o_res.msg_data1         = r_out.msg_data1;
    assign o_res.msg_data2         = r_out.msg_data2;
    assign o_res.sysex_store_valid = r_out.sysex_store_valid;
    assign o_res.sysex_byte        = r_out.sysex_byte;
    assign o_res.sysex_index       = r_out.sysex_index;
    assign o_res.sysex_done        = r_out.sysex_done;
    assign o_res.sysex_length      = r_out.sysex_length;

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_res.ready) |=> (r_out_vld && $stable(r_out)))
        else $error("result changed while stalled");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !o_res.ready) |-> !i_byte.ready)
        else $error("input accepted with both registers full");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_vld)
        else $error("advanced byte did not reach result register");

endmodule

`default_nettype wire
